>>> rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam int unsigned ValW  = 32;
  localparam int unsigned PrioW = 16;
  localparam int unsigned OccW  = 5;
  localparam int unsigned StatW = 2;

  localparam int unsigned InDataW  = ((ValW + PrioW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ValW + PrioW + OccW + 7) / 8) * 8;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0]       prio;
    logic signed [ValW-1:0] value;
  } payload_t;

  typedef struct packed {
    logic     valid;
    payload_t data;
  } entry_t;

  // Broadcast to every cell in the row for one accepted item.
  typedef struct packed {
    logic     ins;
    logic     rem;
    payload_t item;
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_keep_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               keep_o
);

  logic             valid_q, valid_d;
  spq_pkg::payload_t data_q, data_d;

  // An entry stays in place on insert when it is ahead of the new item;
  // equal priority stays ahead so that ties leave in arrival order.
  assign keep_o = valid_q && (data_q.prio <= ctrl_i.item.prio);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          valid_d = 1'b1;
          data_d  = ctrl_i.item;
        end else begin
          valid_d = left_i.valid;
          data_d  = left_i.data;
        end
      end
    end else if (ctrl_i.rem) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.data  = data_q;

endmodule

>>> rtl/stable_priority_queue_top.sv
// Sorted priority queue of spq_pkg::Depth entries; smaller priority leaves first,
// equal priorities leave in arrival order.
// Input channel s_axis: tuser carries the operation (insert or remove head),
// tdata carries the value and priority of an insert.
// Output channel m_axis: exactly one item per accepted input item; tuser holds
// the status (done, remove on empty, insert on full), tdata holds the removed
// value and priority (zero unless a remove succeeded) and the occupancy.
// The entries sit in a row of cells. On insert every cell compares its
// priority with the new one and either holds, loads the new item or takes its
// left neighbor; on remove every cell takes its right neighbor. One compare
// per cell sets the timing, so one item is accepted per cycle.
// The result of an accepted item is in the output register from the cycle after acceptance.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the result waits in the output register and the
// input is held off until it is taken.
// Reset empties the queue and the output register at once; no clearing pass.
module stable_priority_queue_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [31:0] item_value, [47:32] item_priority
  input  logic [spq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] operation
  input  logic [0:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [31:0] removed_value, [47:32] removed_priority, [52:48] occupancy
  output logic [spq_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [spq_pkg::StatW-1:0]    m_axis_tuser_o
);

  localparam int unsigned Depth = spq_pkg::Depth;

  spq_pkg::entry_t    entries [Depth];
  logic [Depth-1:0]   keep;
  spq_pkg::cell_ctrl_t ctrl;

  logic                      accept;
  logic                      full, empty;
  logic [spq_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      out_valid_q;
  spq_pkg::status_e          status;
  logic [spq_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic [spq_pkg::StatW-1:0] out_user_q;
  spq_pkg::payload_t         removed;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = entries[Depth-1].valid;
  assign empty = !entries[0].valid;

  always_comb begin
    ctrl.item.value = s_axis_tdata_i[spq_pkg::ValW-1:0];
    ctrl.item.prio  = s_axis_tdata_i[spq_pkg::ValW +: spq_pkg::PrioW];
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    status   = spq_pkg::ST_DONE;
    cnt_d    = cnt_q;
    removed  = '0;
    if (accept) begin
      if (s_axis_tuser_i == spq_pkg::OP_INSERT) begin
        if (full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.rem = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          removed  = entries[0].data;
        end
      end
    end
    out_data_d = {
      {(spq_pkg::OutDataW - spq_pkg::ValW - spq_pkg::PrioW - spq_pkg::OccW){1'b0}},
      spq_pkg::OccW'(cnt_d),
      removed.prio,
      removed.value
    };
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_keep;

    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = entries[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .entry_o     (entries[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

>>> test/spq_order_checker.sv
`timescale 1ns / 1ps

module spq_order_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  // [31:0] item_value, [47:32] item_priority
  input  logic [spq_pkg::InDataW-1:0]  in_data_i,
  // [0] operation
  input  logic [0:0]                   in_op_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  // [31:0] removed_value, [47:32] removed_priority, [52:48] occupancy
  input  logic [spq_pkg::OutDataW-1:0] out_data_i,
  // [1:0] status
  input  logic [spq_pkg::StatW-1:0]    out_status_i,
  output int                           fail_count_o,
  output int                           pending_count_o,
  output int                           result_count_o,
  output int                           empty_count_o,
  output int                           full_count_o
);
  import spq_pkg::*;

  typedef struct {
    status_e                status;
    logic signed [ValW-1:0] value;
    logic [PrioW-1:0]       prio;
    logic [OccW-1:0]        occ;
  } queue_result_t;

  // Shadow copy of the sorted queue; slot 0 is the head.
  logic signed [ValW-1:0] held_value [Depth];
  logic [PrioW-1:0]       held_prio  [Depth];
  int unsigned            held_count = 0;
  queue_result_t          pending_results [$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= 20) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  task automatic predict_queue_op(input op_e op, input logic signed [ValW-1:0] val,
                                  input logic [PrioW-1:0] pri);
    queue_result_t res;
    int unsigned   pos;
    int unsigned   k;
    res.status = ST_DONE;
    res.value  = '0;
    res.prio   = '0;
    if (op == OP_INSERT) begin
      if (held_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        // A new entry goes behind every entry of equal or smaller priority.
        pos = 0;
        while (pos < held_count && held_prio[pos] <= pri) pos++;
        for (k = held_count; k > pos; k--) begin
          held_value[k] = held_value[k-1];
          held_prio[k]  = held_prio[k-1];
        end
        held_value[pos] = val;
        held_prio[pos]  = pri;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.value = held_value[0];
        res.prio  = held_prio[0];
        for (k = 1; k < held_count; k++) begin
          held_value[k-1] = held_value[k];
          held_prio[k-1]  = held_prio[k];
        end
        held_count--;
      end
    end
    res.occ = OccW'(held_count);
    pending_results.push_back(res);
  endtask

  task automatic check_result();
    queue_result_t          want;
    logic signed [ValW-1:0] got_value;
    logic [PrioW-1:0]       got_prio;
    logic [OccW-1:0]        got_occ;
    got_value = out_data_i[ValW-1:0];
    got_prio  = out_data_i[ValW +: PrioW];
    got_occ   = out_data_i[ValW+PrioW +: OccW];
    result_count_o++;
    if (pending_results.size() == 0) begin
      report_mismatch("result arrived with no item outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (want.status == ST_EMPTY) empty_count_o++;
    if (want.status == ST_FULL) full_count_o++;
    if (out_status_i !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %s", out_status_i, want.status.name()));
    end
    if (got_value !== want.value) begin
      report_mismatch($sformatf("removed value %h, expected %h", got_value, want.value));
    end
    if (got_prio !== want.prio) begin
      report_mismatch($sformatf("removed priority %h, expected %h", got_prio, want.prio));
    end
    if (got_occ !== want.occ) begin
      report_mismatch($sformatf("occupancy %0d, expected %0d", got_occ, want.occ));
    end
  endtask

  // A result at an edge always belongs to an item accepted at an earlier edge,
  // so checking before predicting keeps the order straight.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_count = 0;
      pending_results.delete();
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        predict_queue_op(op_e'(in_op_i), in_data_i[ValW-1:0], in_data_i[ValW +: PrioW]);
      end
      pending_count_o <= pending_results.size();
    end
  end

endmodule

>>> test/stable_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;
  import spq_pkg::*;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [0:0]          s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]    m_axis_tuser_o;

  int fail_count;
  int pending_count;
  int result_count;
  int empty_count;
  int full_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always #2 clk_i = ~clk_i;

  stable_priority_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  spq_order_checker order_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_i      (s_axis_tready_o),
    .in_data_i       (s_axis_tdata_i),
    .in_op_i         (s_axis_tuser_i),
    .out_valid_i     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_data_i      (m_axis_tdata_o),
    .out_status_i    (m_axis_tuser_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .result_count_o  (result_count),
    .empty_count_o   (empty_count),
    .full_count_o    (full_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Idle cycles carry junk on the data lines; the block must ignore it.
  task automatic send_item(input op_e op, input logic [ValW-1:0] val,
                           input logic [PrioW-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= InDataW'({$urandom, $urandom});
      s_axis_tuser_i  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {pri, val};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Bursts lean toward inserts or removes so the queue swings between
  // empty and full; small priorities make ties common.
  task automatic run_random_items(input int unsigned count);
    int unsigned      k;
    int unsigned      burst_left;
    int unsigned      insert_pct;
    logic [PrioW-1:0] pri;
    burst_left = 0;
    insert_pct = 50;
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      case ($urandom_range(9))
        0:       pri = PrioW'($urandom);
        1:       pri = $urandom_range(1) ? '1 : '0;
        default: pri = PrioW'($urandom_range(7));
      endcase
      send_item(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE, $urandom, pri);
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned phase;
    send_idle_pct = 10;
    recv_idle_pct <= 86;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_REMOVE, '1, '1);
    send_item(OP_INSERT, 32'h7fff_ffff, 16'hffff);
    send_item(OP_INSERT, 32'h8000_0000, 16'h0000);
    send_item(OP_INSERT, 32'h0000_0000, 16'h0000);
    send_item(OP_INSERT, 32'hffff_ffff, 16'hffff);
    for (k = 0; k < Depth - 4; k++) begin
      send_item(OP_INSERT, $urandom, PrioW'($urandom_range(2)));
    end
    send_item(OP_INSERT, 32'h1234_5678, 16'h0000);
    repeat (3) send_item(OP_REMOVE, $urandom, PrioW'($urandom));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct <= 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct <= 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      run_random_items(310);
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    $display("Checked %0d results, %0d of them removes on an empty queue and %0d inserts on a full queue.",
             result_count, empty_count, full_count);
    $display("Directed extremes, then random insert and remove bursts under three stall mixes.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", pending_count);
    $display("Some tests failed");
    $finish;
  end

endmodule
